### src/sgr_pkg.sv
// sgr_pkg: widths and reset constants for the stream group reverser.
// No dependencies; used by the core and its checker.
package sgr_pkg;

  localparam int VALUE_W        = 32;
  localparam int GROUP_SIZE_W   = 5;
  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = GROUP_SIZE_W'(2);

  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic [GROUP_SIZE_W-1:0]      group_size_t;

endpackage

### src/stream_group_reverser_core.sv
// stream_group_reverser_core: buffers values in groups and emits each group
// reversed, or a partial group in arrival order at end of sequence.
// Depends on sgr_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, value, is_final       | sink
//  out     | out_valid, out_ready, out_value, run_end, | source
//          | sequence_end                              |
//  cfg     | cfg_valid, cfg_ready, cfg_data            | sink
//
// An item that closes a group of n elements starts a drain of n reads from
// the single-port group buffer, one read a cycle while the output is not
// stalled; input transfers stall until the last read is issued. rst clears
// the fill count, drain count and output valid; buffer contents are not
// cleared. Output stalls hold the read data register and pause the drain.
module stream_group_reverser_core #(
  parameter int MAX_GROUP = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sgr_pkg::value_t      value,
  input  logic                 is_final,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sgr_pkg::value_t      out_value,
  output logic                 run_end,
  output logic                 sequence_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  sgr_pkg::group_size_t cfg_data
);

  localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int CMP_W  = ((CNT_W > sgr_pkg::GROUP_SIZE_W) ? CNT_W : sgr_pkg::GROUP_SIZE_W) + 1;

  sgr_pkg::value_t      mem [MAX_GROUP];
  sgr_pkg::value_t      mem_q;
  sgr_pkg::group_size_t group_size;

  logic [ADDR_W-1:0] fill;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  remaining;
  logic              reverse;
  logic              fin;
  logic              rd_valid;
  logic              rd_last;
  logic              rd_seq;

  logic [CMP_W-1:0]  gs_ext;
  logic [CNT_W-1:0]  g_eff;
  logic [CNT_W-1:0]  n;
  logic              in_xfer;
  logic              trigger;
  logic              move;
  logic              rd_issue;
  logic              issue_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (remaining == '0);
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    gs_ext = CMP_W'(group_size);
    if (gs_ext == '0) begin
      g_eff = CNT_W'(1);
    end else if (gs_ext > CMP_W'(MAX_GROUP)) begin
      g_eff = CNT_W'(MAX_GROUP);
    end else begin
      g_eff = CNT_W'(gs_ext);
    end
  end

  assign n          = CNT_W'(fill) + CNT_W'(1);
  assign trigger    = (n >= g_eff) || is_final;
  assign move       = rd_valid && (!out_valid || out_ready);
  assign rd_issue   = (remaining != '0) && (!rd_valid || move);
  assign issue_last = (remaining == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= sgr_pkg::GROUP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      group_size <= cfg_data;
    end
  end

  // writes happen only with no drain pending, so reads never meet a write
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[fill] <= value;
    end
    if (rd_issue) begin
      mem_q   <= mem[rd_addr];
      rd_last <= issue_last;
      rd_seq  <= issue_last && fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      remaining <= '0;
      rd_addr   <= '0;
      reverse   <= 1'b0;
      fin       <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (trigger) begin
          fill      <= '0;
          remaining <= n;
          reverse   <= (n >= g_eff);
          fin       <= is_final;
          rd_addr   <= (n >= g_eff) ? fill : '0;
        end else begin
          fill <= fill + ADDR_W'(1);
        end
      end else if (rd_issue) begin
        remaining <= remaining - CNT_W'(1);
        rd_addr   <= reverse ? (rd_addr - ADDR_W'(1)) : (rd_addr + ADDR_W'(1));
      end
      if (rd_issue) begin
        rd_valid <= 1'b1;
      end else if (move) begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_value    <= mem_q;
      run_end      <= rd_last;
      sequence_end <= rd_seq;
    end
  end

endmodule

### src/sgr_checker.sv
// sgr_checker: port-level assertions for stream_group_reverser_core,
// attached by the bind below. Depends on sgr_pkg.
module sgr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input sgr_pkg::value_t      value,
  input logic                 is_final,
  input logic                 out_valid,
  input logic                 out_ready,
  input sgr_pkg::value_t      out_value,
  input logic                 run_end,
  input logic                 sequence_end
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(value) && $stable(is_final))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(run_end)
      && $stable(sequence_end))
    else $error("stalled output transfer changed");

  a_seq_end_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_end |-> run_end)
    else $error("sequence_end without run_end");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind stream_group_reverser_core sgr_checker u_sgr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .value        (value),
  .is_final     (is_final),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .run_end      (run_end),
  .sequence_end (sequence_end)
);
